/* rtl/smc_pkg.sv */
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the servo metronome controller.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int unsigned ANGLE_W       = 8;
  localparam int unsigned INTERVAL_BITS = 14;
  localparam int unsigned HOLD_W        = 10;
  localparam int unsigned TOL_W         = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 14;

  localparam int unsigned ANGLE_FULL    = 180;
  localparam int unsigned ANGLE_CENTER  = ANGLE_FULL / 2;

  // Product of elapsed ticks and beat distance, and its quotient
  localparam int unsigned PROD_W = INTERVAL_BITS + ANGLE_W;
  localparam int unsigned QUOT_W = ANGLE_W;

  localparam logic [HOLD_W-1:0]        HOLD_MAX          = '1;
  localparam logic [HOLD_W-1:0]        DEBOUNCE_RESET    = HOLD_W'(200);
  localparam logic [HOLD_W-1:0]        PULSE_RESET       = HOLD_W'(100);
  localparam logic [INTERVAL_BITS-1:0] LONGEST_RESET     = INTERVAL_BITS'(3000);
  localparam logic [INTERVAL_BITS-1:0] SHORTEST_RESET    = INTERVAL_BITS'(500);
  localparam logic [INTERVAL_BITS-1:0] STEP_RESET        = INTERVAL_BITS'(500);
  localparam logic [TOL_W-1:0]         TOLERANCE_RESET   = TOL_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TICKS    = 3'd0,
    CFG_PULSE_TICKS       = 3'd1,
    CFG_INTERVAL_LONGEST  = 3'd2,
    CFG_INTERVAL_SHORTEST = 3'd3,
    CFG_INTERVAL_STEP     = 3'd4,
    CFG_CENTER_TOLERANCE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic start_level;
    logic speed_level;
  } in_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]       servo_position;
    logic                     pulse_active;
    logic                     is_running;
    logic [INTERVAL_BITS-1:0] interval_now;
  } out_rsp_t;

endpackage

/* rtl/smc_debounce.sv */
// ----------------------------------------------------------------------------
// smc_debounce
// Falling-edge press detector with a saturating hold-off counter.
// ----------------------------------------------------------------------------
module smc_debounce (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             level_i,
  input  logic [smc_pkg::HOLD_W-1:0]       debounce_ticks_i,
  output logic                             press_o
);

  logic                        prev_q, prev_d;
  logic [smc_pkg::HOLD_W-1:0]  hold_q, hold_d, hold_inc;

  always_comb begin
    hold_inc = (hold_q == smc_pkg::HOLD_MAX) ? hold_q : hold_q + 1'b1;
    press_o  = !level_i && prev_q &&
               ((hold_inc > debounce_ticks_i) || (hold_inc == smc_pkg::HOLD_MAX));
    hold_d   = press_o ? '0 : hold_inc;
    prev_d   = level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      hold_q <= smc_pkg::HOLD_MAX;
    end else if (step_i) begin
      prev_q <= prev_d;
      hold_q <= hold_d;
    end
  end

endmodule

/* rtl/smc_divider.sv */
// ----------------------------------------------------------------------------
// smc_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUOT_W bits, which holds since elapsed ticks stay below the interval.
// ----------------------------------------------------------------------------
module smc_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [smc_pkg::PROD_W-1:0]        dividend_i,
  input  logic [smc_pkg::INTERVAL_BITS-1:0] divisor_i,
  output logic                              done_o,
  output logic [smc_pkg::QUOT_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(smc_pkg::QUOT_W + 1);
  localparam int unsigned REM_W = smc_pkg::INTERVAL_BITS;

  logic [REM_W-1:0]           rem_q, rem_d;
  logic [smc_pkg::QUOT_W-1:0] low_q, low_d;
  logic [REM_W-1:0]           dvs_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [REM_W:0]             trial;

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, low_q[smc_pkg::QUOT_W-1]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = dividend_i[smc_pkg::PROD_W-1:smc_pkg::QUOT_W];
      low_d  = dividend_i[smc_pkg::QUOT_W-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in the next dividend bit, keep the difference when no borrow
      if (!trial[REM_W]) begin
        rem_d = trial[REM_W-1:0];
      end else begin
        rem_d = {rem_q[REM_W-2:0], low_q[smc_pkg::QUOT_W-1]};
      end
      low_d = {low_q[smc_pkg::QUOT_W-2:0], ~trial[REM_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(smc_pkg::QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

endmodule

/* rtl/servo_metronome_controller.sv */
// ----------------------------------------------------------------------------
// servo_metronome_controller
// Metronome sequencer: debounced start/stop and speed buttons, servo sweep
// angle interpolation with an iterative divider, center pulse.
// ----------------------------------------------------------------------------
// One request is one millisecond tick carrying the two active-low button
// levels; each request yields exactly one response with the servo angle,
// pulse, running flag and current interval. A request that moves the servo
// mid-beat runs through the idle state, which takes the request and resolves
// both buttons, the advance state, which bumps the beat tick count and forms
// the product of elapsed ticks and beat distance, then 8 steps of the shared
// restoring divider (one quotient bit per cycle, set by the angle width), and
// then the finish state for the angle and pulse and the load of the response
// register. Requests that start or stop the metronome or that arrive while
// stopped skip the beat advance, and a request that ends a beat skips the
// divider. in_ready_o is high only while the sequencer is idle; the response
// register lets the next request in while an earlier response still waits to
// be taken, and a request that finishes while that response is still unread
// holds in its last step until it is taken. Configuration is written through a
// plain write port and takes effect as soon as it is registered, also on a request in flight.
// ----------------------------------------------------------------------------
module servo_metronome_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [smc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smc_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  smc_pkg::in_req_t                    in_req_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output smc_pkg::out_rsp_t                   out_rsp_o
);

  localparam int unsigned AW = smc_pkg::ANGLE_W;
  localparam int unsigned IW = smc_pkg::INTERVAL_BITS;

  localparam logic [AW-1:0] FULL   = AW'(smc_pkg::ANGLE_FULL);
  localparam logic [AW-1:0] CENTER = AW'(smc_pkg::ANGLE_CENTER);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADV    = 6'b000010,
    ST_DSTART = 6'b000100,
    ST_DWAIT  = 6'b001000,
    ST_FIN    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [smc_pkg::HOLD_W-1:0] debounce_q;
  logic [smc_pkg::HOLD_W-1:0] pulse_ticks_q;
  logic [IW-1:0]              longest_q;
  logic [IW-1:0]              shortest_q;
  logic [IW-1:0]              step_q;
  logic [smc_pkg::TOL_W-1:0]  tol_q;

  // Metronome state
  logic                       running_q, running_d;
  logic [AW-1:0]              angle_q, angle_d;
  logic                       toward_low_q, toward_low_d;
  logic [AW-1:0]              origin_q, origin_d;
  logic [IW-1:0]              elapsed_q, elapsed_d;
  logic [IW-1:0]              interval_q, interval_d;
  logic [IW-1:0]              latched_q, latched_d;
  logic [AW-1:0]              before_q, before_d;
  logic                       pflag_q, pflag_d;
  logic [smc_pkg::HOLD_W-1:0] prem_q, prem_d;

  logic [smc_pkg::PROD_W-1:0] prod_q, prod_d;

  logic                       out_valid_q, out_valid_d;
  smc_pkg::out_rsp_t          out_q;
  logic                       out_load;

  // Datapath helpers
  logic                       accept;
  logic                       start_press, speed_press;
  logic [IW:0]                wrap_limit;
  logic [AW-1:0]              end_pt;
  logic [AW-1:0]              span;
  logic [IW-1:0]              elapsed_inc;
  logic [smc_pkg::QUOT_W-1:0] quotient;
  logic                       div_done;
  logic [AW:0]                cur_sum;
  logic [AW-1:0]              cur;
  logic [AW-1:0]              dist_prev, dist_cur;
  logic [smc_pkg::HOLD_W-1:0] prem_dec;
  logic                       pflag_mid;

  function automatic logic [AW-1:0] center_dist(input logic [AW-1:0] a);
    center_dist = (a >= CENTER) ? a - CENTER : CENTER - a;
  endfunction

  assign accept = in_valid_i && in_ready_o;

  // Button front ends, advanced once per request
  smc_debounce u_start_db (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .level_i          (in_req_i.start_level),
    .debounce_ticks_i (debounce_q),
    .press_o          (start_press)
  );

  smc_debounce u_speed_db (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .level_i          (in_req_i.speed_level),
    .debounce_ticks_i (debounce_q),
    .press_o          (speed_press)
  );

  // Divider: elapsed * distance / latched interval
  smc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DSTART),
    .dividend_i (prod_q),
    .divisor_i  (latched_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= smc_pkg::DEBOUNCE_RESET;
      pulse_ticks_q <= smc_pkg::PULSE_RESET;
      longest_q     <= smc_pkg::LONGEST_RESET;
      shortest_q    <= smc_pkg::SHORTEST_RESET;
      step_q        <= smc_pkg::STEP_RESET;
      tol_q         <= smc_pkg::TOLERANCE_RESET;
    end else if (cfg_we_i) begin
      unique case (smc_pkg::cfg_reg_e'(cfg_idx_i))
        smc_pkg::CFG_DEBOUNCE_TICKS:    debounce_q    <= cfg_data_i[smc_pkg::HOLD_W-1:0];
        smc_pkg::CFG_PULSE_TICKS:       pulse_ticks_q <= cfg_data_i[smc_pkg::HOLD_W-1:0];
        smc_pkg::CFG_INTERVAL_LONGEST:  longest_q     <= cfg_data_i[IW-1:0];
        smc_pkg::CFG_INTERVAL_SHORTEST: shortest_q    <= cfg_data_i[IW-1:0];
        smc_pkg::CFG_INTERVAL_STEP:     step_q        <= cfg_data_i[IW-1:0];
        smc_pkg::CFG_CENTER_TOLERANCE:  tol_q         <= cfg_data_i[smc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Beat geometry of the current beat
  always_comb begin
    end_pt      = toward_low_q ? '0 : FULL;
    span        = (end_pt >= origin_q) ? end_pt - origin_q : origin_q - end_pt;
    elapsed_inc = elapsed_q + 1'b1;
    wrap_limit  = {1'b0, step_q} + {1'b0, shortest_q};
  end

  // Angle and pulse for a mid-beat tick
  always_comb begin
    if (end_pt >= origin_q) begin
      cur_sum = {1'b0, origin_q} + {1'b0, quotient};
    end else begin
      cur_sum = {1'b0, origin_q} - {1'b0, quotient};
    end
    cur       = (cur_sum > {1'b0, FULL}) ? FULL : cur_sum[AW-1:0];
    dist_prev = center_dist(before_q);
    dist_cur  = center_dist(cur);
    prem_dec  = (pflag_q && prem_q != '0) ? prem_q - 1'b1 : prem_q;
    pflag_mid = pflag_q;
    if (!pflag_q && dist_prev > dist_cur && dist_cur <= AW'(tol_q)) begin
      pflag_mid = 1'b1;
      prem_dec  = pulse_ticks_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    angle_d      = angle_q;
    toward_low_d = toward_low_q;
    origin_d     = origin_q;
    elapsed_d    = elapsed_q;
    interval_d   = interval_q;
    latched_d    = latched_q;
    before_d     = before_q;
    pflag_d      = pflag_q;
    prem_d       = prem_q;
    prod_d       = prod_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = running_q ? ST_ADV : ST_DONE;
          if (start_press) begin
            state_d = ST_DONE;
            angle_d = '0;
            pflag_d = 1'b0;
            prem_d  = '0;
            if (!running_q) begin
              // Begin the first beat toward full scale from zero
              running_d    = 1'b1;
              toward_low_d = 1'b0;
              origin_d     = '0;
              elapsed_d    = '0;
              latched_d    = interval_q;
              before_d     = '0;
            end else begin
              running_d = 1'b0;
            end
          end
          if (speed_press) begin
            // Shorten the interval, wrap to longest below the shortest
            if ({1'b0, interval_q} < wrap_limit) begin
              interval_d = longest_q;
            end else begin
              interval_d = interval_q - step_q;
            end
          end
        end
      end
      ST_ADV: begin
        elapsed_d = elapsed_inc;
        if (latched_q == '0 || elapsed_inc >= latched_q) begin
          // Land on the end point and begin the next beat
          angle_d      = end_pt;
          toward_low_d = !toward_low_q;
          origin_d     = end_pt;
          elapsed_d    = '0;
          latched_d    = interval_q;
          before_d     = end_pt;
          pflag_d      = 1'b0;
          prem_d       = '0;
          state_d      = ST_DONE;
        end else begin
          prod_d  = smc_pkg::PROD_W'(elapsed_inc) * smc_pkg::PROD_W'(span);
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        angle_d  = cur;
        before_d = cur;
        prem_d   = prem_dec;
        pflag_d  = pflag_mid && (prem_dec != '0);
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the response register is free
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      running_q    <= 1'b0;
      angle_q      <= '0;
      toward_low_q <= 1'b0;
      origin_q     <= '0;
      elapsed_q    <= '0;
      interval_q   <= smc_pkg::LONGEST_RESET;
      latched_q    <= smc_pkg::LONGEST_RESET;
      before_q     <= '0;
      pflag_q      <= 1'b0;
      prem_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      angle_q      <= angle_d;
      toward_low_q <= toward_low_d;
      origin_q     <= origin_d;
      elapsed_q    <= elapsed_d;
      interval_q   <= interval_d;
      latched_q    <= latched_d;
      before_q     <= before_d;
      pflag_q      <= pflag_d;
      prem_q       <= prem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (out_load) begin
      out_q.servo_position <= angle_q;
      out_q.pulse_active   <= pflag_q;
      out_q.is_running     <= running_q;
      out_q.interval_now   <= interval_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* tb/sv/tb_servo_metronome_controller.sv */
// ----------------------------------------------------------------------------
// tb_servo_metronome_controller
// Self-checking bench for the servo metronome controller: ticks with two
// button levels go in over valid/ready, and a cycle-free model predicts every
// response (angle, pulse, running flag, interval). Covers debounce, start and
// stop, speed wrap, beat turnaround and the center pulse under several register
// settings, with random idling on both sides and back-pressure episodes.
// ----------------------------------------------------------------------------
module tb_servo_metronome_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch the response side is held off, and the watchdog limit.
  // The slowest correct request plus the longest sender gap and stalled response
  // cycles stay far below the watchdog limit, so reaching it can only mean a
  // hang. The hold-off itself stays well below that.
  localparam int unsigned RSP_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYCLES   = 16;

  // --------------------------------------------------------------------------
  // Metronome predictor and response store
  // --------------------------------------------------------------------------
  class tick_scoreboard;
    // register copies
    logic [smc_pkg::HOLD_W-1:0]        debounce_ticks, pulse_ticks;
    logic [smc_pkg::INTERVAL_BITS-1:0] interval_longest, interval_shortest, interval_dec;
    logic [smc_pkg::TOL_W-1:0]         tolerance;
    // metronome state
    bit                                running, toward_low, pulse_on, start_prev, speed_prev;
    logic [smc_pkg::ANGLE_W-1:0]       angle, origin, angle_prev;
    logic [smc_pkg::INTERVAL_BITS-1:0] elapsed, interval_cur, interval_beat;
    logic [smc_pkg::HOLD_W-1:0]        pulse_left, start_hold, speed_hold;

    smc_pkg::out_rsp_t expected_q[$];
    int unsigned errors, ticks, starts, stops, speed_presses, beats, pulses;

    function new();
      debounce_ticks    = smc_pkg::DEBOUNCE_RESET;
      pulse_ticks       = smc_pkg::PULSE_RESET;
      interval_longest  = smc_pkg::LONGEST_RESET;
      interval_shortest = smc_pkg::SHORTEST_RESET;
      interval_dec      = smc_pkg::STEP_RESET;
      tolerance         = smc_pkg::TOLERANCE_RESET;
      running       = 1'b0;
      toward_low    = 1'b0;
      pulse_on      = 1'b0;
      angle         = '0;
      origin        = '0;
      angle_prev    = '0;
      elapsed       = '0;
      interval_cur  = smc_pkg::LONGEST_RESET;
      interval_beat = smc_pkg::LONGEST_RESET;
      pulse_left    = '0;
      start_prev    = 1'b1;
      speed_prev    = 1'b1;
      start_hold    = smc_pkg::HOLD_MAX;
      speed_hold    = smc_pkg::HOLD_MAX;
    endfunction

    function void set_reg(smc_pkg::cfg_reg_e idx, logic [smc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        smc_pkg::CFG_DEBOUNCE_TICKS:    debounce_ticks    = val[smc_pkg::HOLD_W-1:0];
        smc_pkg::CFG_PULSE_TICKS:       pulse_ticks       = val[smc_pkg::HOLD_W-1:0];
        smc_pkg::CFG_INTERVAL_LONGEST:  interval_longest  = val[smc_pkg::INTERVAL_BITS-1:0];
        smc_pkg::CFG_INTERVAL_SHORTEST: interval_shortest = val[smc_pkg::INTERVAL_BITS-1:0];
        smc_pkg::CFG_INTERVAL_STEP:     interval_dec      = val[smc_pkg::INTERVAL_BITS-1:0];
        smc_pkg::CFG_CENTER_TOLERANCE:  tolerance         = val[smc_pkg::TOL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Falling edge with the hold-off either expired or saturated
    function bit take_press(input logic level, inout bit prev,
                            inout logic [smc_pkg::HOLD_W-1:0] hold);
      bit ok;
      ok = 1'b0;
      if (hold < smc_pkg::HOLD_MAX) hold++;
      if (level == 1'b0 && prev == 1'b1 &&
          (hold > debounce_ticks || hold == smc_pkg::HOLD_MAX)) begin
        ok   = 1'b1;
        hold = '0;
      end
      prev = level;
      return ok;
    endfunction

    function void open_beat();
      origin        = angle;
      elapsed       = '0;
      interval_beat = interval_cur;
      angle_prev    = angle;
      pulse_on      = 1'b0;
      pulse_left    = '0;
    endfunction

    function int unsigned off_center(int unsigned a);
      return (a >= smc_pkg::ANGLE_CENTER) ? a - smc_pkg::ANGLE_CENTER
                                          : smc_pkg::ANGLE_CENTER - a;
    endfunction

    function void step_beat();
      int unsigned goal, span, part, cur, dp, dc;
      goal = toward_low ? 0 : smc_pkg::ANGLE_FULL;
      span = (goal >= origin) ? goal - origin : origin - goal;
      elapsed = elapsed + 1'b1;
      // turn around at the end of the beat
      if (interval_beat == 0 || elapsed >= interval_beat) begin
        angle      = smc_pkg::ANGLE_W'(goal);
        toward_low = !toward_low;
        beats++;
        open_beat();
        return;
      end
      part = (elapsed * span) / interval_beat;
      if (part > span) part = span;
      cur = (goal >= origin) ? origin + part : origin - part;
      if (cur > smc_pkg::ANGLE_FULL) cur = smc_pkg::ANGLE_FULL;
      angle = smc_pkg::ANGLE_W'(cur);

      if (pulse_on && pulse_left > 0) pulse_left--;
      if (!pulse_on) begin
        dp = off_center(angle_prev);
        dc = off_center(cur);
        if (dp > dc && dc <= tolerance) begin
          pulse_on   = 1'b1;
          pulse_left = pulse_ticks;
          pulses++;
        end
      end
      if (pulse_on && pulse_left == 0) pulse_on = 1'b0;
      angle_prev = smc_pkg::ANGLE_W'(cur);
    endfunction

    function void note_request(smc_pkg::in_req_t req);
      bit started;
      smc_pkg::out_rsp_t rsp;
      started = 1'b0;
      ticks++;
      if (take_press(req.start_level, start_prev, start_hold)) begin
        if (!running) begin
          running    = 1'b1;
          angle      = '0;
          toward_low = 1'b0;
          open_beat();
          started    = 1'b1;
          starts++;
        end else begin
          running    = 1'b0;
          angle      = '0;
          pulse_on   = 1'b0;
          pulse_left = '0;
          stops++;
        end
      end
      if (take_press(req.speed_level, speed_prev, speed_hold)) begin
        speed_presses++;
        if (interval_cur < interval_dec || interval_cur - interval_dec < interval_shortest)
          interval_cur = interval_longest;
        else
          interval_cur = interval_cur - interval_dec;
      end
      if (running && !started) step_beat();
      rsp.servo_position = angle;
      rsp.pulse_active   = pulse_on;
      rsp.is_running     = running;
      rsp.interval_now   = interval_cur;
      expected_q.push_back(rsp);
    endfunction

    function void check_response(smc_pkg::out_rsp_t rsp);
      smc_pkg::out_rsp_t exp_rsp;
      if (expected_q.size() == 0) begin
        $error("response with no request waiting: %p", rsp);
        errors++;
        return;
      end
      exp_rsp = expected_q.pop_front();
      if (rsp.servo_position !== exp_rsp.servo_position) begin
        $error("servo_position: expected %0d, got %0d", exp_rsp.servo_position,
               rsp.servo_position);
        errors++;
      end
      if (rsp.pulse_active !== exp_rsp.pulse_active) begin
        $error("pulse_active: expected %0d, got %0d", exp_rsp.pulse_active, rsp.pulse_active);
        errors++;
      end
      if (rsp.is_running !== exp_rsp.is_running) begin
        $error("is_running: expected %0d, got %0d", exp_rsp.is_running, rsp.is_running);
        errors++;
      end
      if (rsp.interval_now !== exp_rsp.interval_now) begin
        $error("interval_now: expected %0d, got %0d", exp_rsp.interval_now, rsp.interval_now);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [smc_pkg::CFG_IDX_W-1:0]     cfg_idx_i;
  logic [smc_pkg::CFG_DATA_W-1:0]    cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  smc_pkg::in_req_t                  in_req_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  smc_pkg::out_rsp_t                 out_rsp_o;

  tick_scoreboard sb = new();

  // idling percentages of the current phase
  int unsigned req_idle_pct  = 0;
  int unsigned rsp_stall_pct = 0;
  // set by the sequence to ask the response side for a long hold-off
  bit          rsp_hold_req  = 1'b0;
  int unsigned stuck_cycles  = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  servo_metronome_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // --------------------------------------------------------------------------
  // Response side: random stalls, plus a long hold-off on request. Ready only
  // moves at the falling edge, so every handshake is seen cleanly at the rise.
  // --------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_req) begin
        // hold ready low long enough for the block to fill and stall its input
        out_ready_i <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk_i);
        rsp_hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Check responses and watch for a hang; values read here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, sb.pending());
        $display("Regression FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks; all are entered and left at a falling edge
  // --------------------------------------------------------------------------
  function automatic smc_pkg::in_req_t levels(bit start_lvl, bit speed_lvl);
    smc_pkg::in_req_t req;
    req.start_level = start_lvl;
    req.speed_level = speed_lvl;
    return req;
  endfunction

  task automatic set_idling(int unsigned req_pct, int unsigned rsp_pct);
    req_idle_pct  = req_pct;
    rsp_stall_pct = rsp_pct;
  endtask

  // Offer one tick, maybe after an idle gap, and hold it until taken
  task automatic send_tick(smc_pkg::in_req_t req);
    if ($urandom_range(99) < req_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted response has come back
  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    @(negedge clk_i);
  endtask

  task automatic put_reg(smc_pkg::cfg_reg_e idx, logic [smc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Write all six registers with the block idle
  task automatic apply_settings(int unsigned debounce, int unsigned pulse,
                                int unsigned longest, int unsigned shortest,
                                int unsigned dec, int unsigned tol);
    drain_responses();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    put_reg(smc_pkg::CFG_DEBOUNCE_TICKS,    smc_pkg::CFG_DATA_W'(debounce));
    put_reg(smc_pkg::CFG_PULSE_TICKS,       smc_pkg::CFG_DATA_W'(pulse));
    put_reg(smc_pkg::CFG_INTERVAL_LONGEST,  smc_pkg::CFG_DATA_W'(longest));
    put_reg(smc_pkg::CFG_INTERVAL_SHORTEST, smc_pkg::CFG_DATA_W'(shortest));
    put_reg(smc_pkg::CFG_INTERVAL_STEP,     smc_pkg::CFG_DATA_W'(dec));
    put_reg(smc_pkg::CFG_CENTER_TOLERANCE,  smc_pkg::CFG_DATA_W'(tol));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly button presses held for a few ticks and released, with some
  // ticks of raw random levels mixed in as contact noise.
  task automatic random_ticks(int unsigned count);
    int unsigned      start_left, speed_left;
    smc_pkg::in_req_t req;
    start_left = 0;
    speed_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        req = smc_pkg::in_req_t'(2'($urandom_range(3)));
      end else begin
        if (start_left == 0 && $urandom_range(99) < 3) start_left = $urandom_range(1, 4);
        if (speed_left == 0 && $urandom_range(99) < 6) speed_left = $urandom_range(1, 3);
        req = levels(start_left == 0, speed_left == 0);
        if (start_left != 0) start_left--;
        if (speed_left != 0) speed_left--;
      end
      send_tick(req);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = smc_pkg::CFG_DEBOUNCE_TICKS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_req_i   = levels(1'b1, 1'b1);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, reset settings: both buttons pressed together on the second
    // tick (saturated hold-off lets both through), then a start press that
    // the 200-tick debounce must reject.
    set_idling(0, 0);
    send_tick(levels(1'b1, 1'b1));
    send_tick(levels(1'b0, 1'b0));
    send_tick(levels(1'b0, 1'b0));
    send_tick(levels(1'b1, 1'b1));
    send_tick(levels(1'b0, 1'b1));
    send_tick(levels(1'b1, 1'b1));

    // Directed, no debounce and a step larger than any interval: speed wraps
    // to the longest interval, stop, restart, then a full six-tick beat with
    // a one-tick pulse at the center, turnaround, and stop plus wrap at once.
    apply_settings(0, 1, 6, 2, 16383, 15);
    send_tick(levels(1'b1, 1'b0));
    send_tick(levels(1'b0, 1'b1));
    send_tick(levels(1'b1, 1'b1));
    send_tick(levels(1'b0, 1'b1));
    repeat (7) send_tick(levels(1'b1, 1'b1));
    send_tick(levels(1'b0, 1'b0));

    // Random phase 1: no idling, short beats, zero tolerance, unit step.
    // Midway the response side holds off while ticks keep coming.
    apply_settings(0, 1, 40, 1, 1, 0);
    random_ticks(100);
    rsp_hold_req = 1'b1;
    random_ticks(40);
    random_ticks(105);

    // Random phase 2: sender idles; extreme debounce, pulse and intervals
    apply_settings(1023, 1023, 16383, 16383, 16383, 15);
    set_idling(48, 0);
    random_ticks(245);

    // Random phase 3: receiver stalls; pause the sender midway until drained
    apply_settings(5, 7, 25, 3, 4, 3);
    set_idling(0, 48);
    random_ticks(120);
    drain_responses();
    random_ticks(125);

    // Random phase 4: light idling on both sides; shortest equals longest
    apply_settings(2, 20, 12, 12, 5, 15);
    set_idling(7, 7);
    random_ticks(245);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks over 6 register settings: %0d starts, %0d stops, %0d speed presses,",
             sb.ticks, sb.starts, sb.stops, sb.speed_presses);
    $display("%0d beats completed and %0d center pulses fired, %0d mismatches.",
             sb.beats, sb.pulses, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/smc_pkg.sv
rtl/smc_debounce.sv
rtl/smc_divider.sv
rtl/servo_metronome_controller.sv
tb/sv/tb_servo_metronome_controller.sv
